>>> hw/rtl/pbs_pkg.sv
// pbs_pkg: shared widths, codes and record types of the priority batch scheduler
// no dependencies; imported by pbs_unit and priority_batch_scheduler_top
package pbs_pkg;

   localparam int PRIO_W  = 4;
   localparam int BURST_W = 16;
   localparam int ID_W    = 8;
   localparam int TIME_W  = 24;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_RUN = 1'b1;

   localparam logic STATUS_SCHED = 1'b0;
   localparam logic STATUS_DROP  = 1'b1;

   // one stored task, as held in the table ram
   typedef struct packed {
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
      logic [ID_W-1:0]    id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // what the shared step unit hands back to the sequencer
   typedef struct packed {
      logic [TIME_W-1:0] sum_time;
      logic              shift;
   } unit_res_type;

endpackage

>>> hw/rtl/pbs_ram.sv
// pbs_ram: generic single write port, single read port ram with registered read
// no dependencies
module pbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pbs_unit.sv
// pbs_unit: shared step unit, saturating clock advance and priority compare
// depends on pbs_pkg
module pbs_unit (
   input  logic [pbs_pkg::TIME_W-1:0]  time_in,
   input  logic [pbs_pkg::BURST_W-1:0] burst,
   input  logic [pbs_pkg::PRIO_W-1:0]  prio_entry,
   input  logic [pbs_pkg::PRIO_W-1:0]  prio_new,
   output pbs_pkg::unit_res_type       res
);
   import pbs_pkg::*;

   logic [TIME_W:0] sum_wide;

   always_comb begin
      sum_wide     = {1'b0, time_in} + {{(TIME_W + 1 - BURST_W){1'b0}}, burst};
      res.sum_time = sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];
      // stored entry moves up one slot when it is not more urgent than the new one
      res.shift    = (prio_entry >= prio_new);
   end

endmodule

>>> hw/rtl/priority_batch_scheduler_top.sv
// priority_batch_scheduler_top: task table sorted by priority in one ram, drained on a run
// add: moves lower entries that are not more urgent up one slot, then writes the new task
// run: per task a registered ram read, then execute, then the result waits for rsp_ready
// full-table add: drop item comes the cycle after acceptance; req_ready is low meanwhile
// synchronous active-high reset empties the table, zeroes task ids and clock; no clearing pass
// depends on pbs_pkg, pbs_ram, pbs_unit
module priority_batch_scheduler_top #(
   parameter int MAX_TASKS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic [pbs_pkg::PRIO_W-1:0]  req_task_priority,
   input  logic [pbs_pkg::BURST_W-1:0] req_task_burst,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pbs_pkg::ID_W-1:0]    rsp_task_id,
   output logic [pbs_pkg::TIME_W-1:0]  rsp_start_time,
   output logic [pbs_pkg::TIME_W-1:0]  rsp_finish_time,
   output logic                        rsp_status,
   output logic                        rsp_last
);
   import pbs_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_INS_RD  = 6'b000010,
      ST_INS_CMP = 6'b000100,
      ST_RUN_RD  = 6'b001000,
      ST_RUN_EXE = 6'b010000,
      ST_RESP    = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [TIME_W-1:0]  elapsed_ff, elapsed_in;
   logic [PRIO_W-1:0]  new_prio_ff, new_prio_in;
   logic [BURST_W-1:0] new_burst_ff, new_burst_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [TIME_W-1:0]  rsp_finish_ff, rsp_finish_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          rd_entry;
   entry_type          new_entry;
   unit_res_type       unit_res;
   logic               full;
   logic               run_last;

   pbs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pbs_unit u_unit (
      .time_in    (elapsed_ff),
      .burst      (rd_entry.burst),
      .prio_entry (rd_entry.prio),
      .prio_new   (new_prio_ff),
      .res        (unit_res)
   );

   assign rd_entry  = entry_type'(rd_data);
   assign new_entry = '{prio: new_prio_ff, burst: new_burst_ff, id: next_id_ff};
   assign full      = (count_ff == CNT_W'(MAX_TASKS));
   assign run_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      next_id_in    = next_id_ff;
      elapsed_in    = elapsed_ff;
      new_prio_in   = new_prio_ff;
      new_burst_in  = new_burst_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_finish_in = rsp_finish_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = new_entry;
      rd_addr       = idx_ff;
      req_ready     = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_ADD) begin
                  if (full) begin
                     rsp_id_in     = next_id_ff;
                     rsp_start_in  = '0;
                     rsp_finish_in = '0;
                     rsp_status_in = STATUS_DROP;
                     rsp_last_in   = 1'b1;
                     rsp_valid_in  = 1'b1;
                     state_in      = ST_RESP;
                  end else begin
                     new_prio_in  = req_task_priority;
                     new_burst_in = req_task_burst;
                     idx_in       = count_ff[IDX_W-1:0];
                     state_in     = ST_INS_RD;
                  end
               end else if (count_ff != '0) begin
                  idx_in   = '0;
                  state_in = ST_RUN_RD;
               end
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en      = 1'b1;
               count_in   = count_ff + CNT_W'(1);
               next_id_in = next_id_ff + ID_W'(1);
               state_in   = ST_IDLE;
            end else begin
               rd_addr  = idx_ff - IDX_W'(1);
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (unit_res.shift) begin
               // move the neighbour below up one slot and keep walking down
               wr_data  = rd_entry;
               idx_in   = idx_ff - IDX_W'(1);
               state_in = ST_INS_RD;
            end else begin
               count_in   = count_ff + CNT_W'(1);
               next_id_in = next_id_ff + ID_W'(1);
               state_in   = ST_IDLE;
            end
         end
         ST_RUN_RD: begin
            state_in = ST_RUN_EXE;
         end
         ST_RUN_EXE: begin
            rsp_id_in     = rd_entry.id;
            rsp_start_in  = elapsed_ff;
            rsp_finish_in = unit_res.sum_time;
            rsp_status_in = STATUS_SCHED;
            rsp_last_in   = run_last;
            rsp_valid_in  = 1'b1;
            elapsed_in    = unit_res.sum_time;
            if (run_last) begin
               count_in = '0;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_RUN_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         next_id_ff   <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      new_prio_ff   <= new_prio_in;
      new_burst_ff  <= new_burst_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_finish_ff <= rsp_finish_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_task_id     = rsp_id_ff;
   assign rsp_start_time  = rsp_start_ff;
   assign rsp_finish_time = rsp_finish_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last        = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TASKS))
      else $error("task count beyond table depth");

   a_valid_in_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff == (state_ff == ST_RESP))
      else $error("result valid outside response state");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_DROP) |-> full && rsp_last_ff)
      else $error("drop item without a full table");

   a_run_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && rsp_last_ff && (rsp_status_ff == STATUS_SCHED)
      |=> count_ff == '0)
      else $error("table not empty after last run item");

   a_clock_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> elapsed_ff >= $past(elapsed_ff))
      else $error("running clock went backwards");

endmodule
